[rtl/cfa_pkg.sv]
// shared constants for the contiguous fit allocator
// field widths, command, fit and status codes, parameter defaults; no dependencies
package cfa_pkg;

    localparam int FIELD_W     = 21;
    localparam int CMD_W       = 2;
    localparam int FIT_W       = 2;
    localparam int STATUS_W    = 2;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int ADDR_BITS_DEF   = 20;
    localparam int OWNER_BITS_DEF  = 8;

    localparam logic [CMD_W-1:0] CMD_REQUEST = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;

    localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 2'd3;

endpackage

[rtl/cfa_ram.sv]
// single write port, single read port synchronous table memory
// registered read; no dependencies
module cfa_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 65
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[rtl/contiguous_fit_allocator.sv]
// contiguous region allocator with first, best and worst fit over a hole table
// depends on cfa_pkg and cfa_ram (hole table and block table memories)
//
// usage:
//   cfg channel (cfg_valid/cfg_ready, mem_bytes) sets the managed size; a write
//   reloads the tables with one hole covering all of memory and no blocks. it is
//   taken only while the block is idle.
//   in channel carries one item: command, owner_id, request_size, fit_strategy.
//   out channel returns one item per input item: status, region_start, region_end.
// timing:
//   hole and block tables sit in synchronous memories with a registered read, one entry read
//   and one written per cycle. a request scans the holes, then rewrites them in a second
//   pass. a release scans the blocks, moves the last block into the freed slot, then
//   merges and rewrites holes. compaction is one pass over the blocks. each item is
//   accepted in idle and its result is then loaded into the output register. items
//   are handled one at a time.
// reset and stall:
//   after reset (and after each cfg write) the init state writes hole entry zero
//   before in_ready rises. a finished item waits in the output register; a new
//   item is accepted meanwhile, but its result waits until the output is free.
module contiguous_fit_allocator #(
    parameter int TABLE_DEPTH = cfa_pkg::TABLE_DEPTH_DEF,
    parameter int ADDR_BITS   = cfa_pkg::ADDR_BITS_DEF,
    parameter int OWNER_BITS  = cfa_pkg::OWNER_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [cfa_pkg::FIELD_W-1:0]   mem_bytes,
    // command items
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [cfa_pkg::CMD_W-1:0]     command,
    input  logic [OWNER_BITS-1:0]         owner_id,
    input  logic [cfa_pkg::FIELD_W-1:0]   request_size,
    input  logic [cfa_pkg::FIT_W-1:0]     fit_strategy,
    // result items
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [cfa_pkg::STATUS_W-1:0]  status,
    output logic [cfa_pkg::FIELD_W-1:0]   region_start,
    output logic [cfa_pkg::FIELD_W-1:0]   region_end
);

    localparam int FW    = cfa_pkg::FIELD_W;
    localparam int AW    = ADDR_BITS;
    localparam int VW    = ADDR_BITS + 1;
    localparam int SW    = (VW > FW) ? VW : FW;
    localparam int HD    = TABLE_DEPTH + 1;
    localparam int HIW   = $clog2(HD);
    localparam int BIW   = $clog2(TABLE_DEPTH);
    localparam int CW    = $clog2(TABLE_DEPTH + 2);
    localparam int HWID  = 2 * AW;
    localparam int BWID  = OWNER_BITS + 2 * AW;
    localparam logic [VW-1:0] MSIZE_RST =
        VW'((AW >= 20) ? 64'd1048576 : (64'd1 << AW));
    localparam logic [63:0] MSIZE_MAX = 64'd1 << AW;

    // sequencer states
    localparam logic [2:0] S_INIT      = 3'd0;
    localparam logic [2:0] S_IDLE      = 3'd1;
    localparam logic [2:0] S_RQ_SCAN   = 3'd2;
    localparam logic [2:0] S_BL_SCAN   = 3'd3;
    localparam logic [2:0] S_BL_MOVE   = 3'd4;
    localparam logic [2:0] S_HOLE_PASS = 3'd5;
    localparam logic [2:0] S_CP_PASS   = 3'd6;
    localparam logic [2:0] S_OUT       = 3'd7;

    logic [2:0]                   state_reg, state_next;
    logic [VW-1:0]                msize_reg, msize_next;
    logic [CW-1:0]                hole_cnt_reg, hole_cnt_next;
    logic [CW-1:0]                blk_cnt_reg, blk_cnt_next;
    logic [OWNER_BITS-1:0]        owner_reg, owner_next;
    logic [FW-1:0]                size_reg, size_next;
    logic [cfa_pkg::FIT_W-1:0]    fit_reg, fit_next;
    logic [CW-1:0]                rd_cnt_reg, rd_cnt_next;
    logic                         dv_reg, dv_next;
    logic [CW-1:0]                di_reg, di_next;
    logic [CW-1:0]                wr_cnt_reg, wr_cnt_next;
    logic                         found_reg, found_next;
    logic [CW-1:0]                pick_reg, pick_next;
    logic [SW-1:0]                pick_size_reg, pick_size_next;
    logic [AW-1:0]                pick_last_reg, pick_last_next;
    logic                         drop_reg, drop_next;
    logic                         rel_mode_reg, rel_mode_next;
    logic [cfa_pkg::STATUS_W-1:0] st_reg, st_next;
    logic [VW-1:0]                rs_reg, rs_next;
    logic [VW-1:0]                re_reg, re_next;
    logic                         out_valid_reg, out_valid_next;
    logic [cfa_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [FW-1:0]                region_start_reg, region_start_next;
    logic [FW-1:0]                region_end_reg, region_end_next;

    // memory ports
    logic            h_we;
    logic [HIW-1:0]  h_waddr, h_raddr;
    logic [HWID-1:0] h_wdata, h_rdata;
    logic            b_we;
    logic [BIW-1:0]  b_waddr, b_raddr;
    logic [BWID-1:0] b_wdata, b_rdata;

    // decoded read data
    logic [AW-1:0]         h_first, h_last, b_first, b_last;
    logic [OWNER_BITS-1:0] b_owner;
    logic [SW-1:0]         hs;
    logic [VW-1:0]         bs;
    logic [CW-1:0]         scan_lim;
    logic                  issue, scan_done, take, keep;
    logic [SW-1:0]         re_calc;
    logic [VW-1:0]         cp_last;
    logic [63:0]           cfg_sat;

    cfa_ram #(.WIDTH(HWID), .DEPTH(HD)) u_hole_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (h_wdata),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    cfa_ram #(.WIDTH(BWID), .DEPTH(TABLE_DEPTH)) u_block_ram (
        .clk   (clk),
        .we    (b_we),
        .waddr (b_waddr),
        .wdata (b_wdata),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

    assign h_first = h_rdata[HWID-1:AW];
    assign h_last  = h_rdata[AW-1:0];
    assign b_owner = b_rdata[BWID-1:2*AW];
    assign b_first = b_rdata[2*AW-1:AW];
    assign b_last  = b_rdata[AW-1:0];
    assign hs      = SW'(h_last) - SW'(h_first) + SW'(1);
    assign bs      = VW'(b_last) - VW'(b_first) + VW'(1);
    assign cp_last = rs_reg + bs - VW'(1);
    assign re_calc = SW'(rs_reg) + SW'(size_reg) - SW'(1);

    // zero reads as one, oversize saturates to the full address space
    always_comb
    begin
        cfg_sat = 64'(mem_bytes);
        if (cfg_sat == 64'd0)
        begin
            cfg_sat = 64'd1;
        end
        else if (cfg_sat > MSIZE_MAX)
        begin
            cfg_sat = MSIZE_MAX;
        end
    end

    // scans read one entry per cycle; data comes back in the next cycle, tagged with its index
    assign scan_lim  = ((state_reg == S_RQ_SCAN) || (state_reg == S_HOLE_PASS)) ?
                       hole_cnt_reg : blk_cnt_reg;
    assign issue     = (rd_cnt_reg < scan_lim);
    assign scan_done = !issue && !dv_reg;

    assign cfg_ready = (state_reg == S_IDLE);
    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;

    always_comb
    begin
        state_next        = state_reg;
        msize_next        = msize_reg;
        hole_cnt_next     = hole_cnt_reg;
        blk_cnt_next      = blk_cnt_reg;
        owner_next        = owner_reg;
        size_next         = size_reg;
        fit_next          = fit_reg;
        rd_cnt_next       = rd_cnt_reg;
        dv_next           = 1'b0;
        di_next           = rd_cnt_reg;
        wr_cnt_next       = wr_cnt_reg;
        found_next        = found_reg;
        pick_next         = pick_reg;
        pick_size_next    = pick_size_reg;
        pick_last_next    = pick_last_reg;
        drop_next         = drop_reg;
        rel_mode_next     = rel_mode_reg;
        st_next           = st_reg;
        rs_next           = rs_reg;
        re_next           = re_reg;
        out_valid_next    = out_valid_reg;
        status_next       = status_reg;
        region_start_next = region_start_reg;
        region_end_next   = region_end_reg;
        h_we              = 1'b0;
        h_waddr           = wr_cnt_reg[HIW-1:0];
        h_wdata           = h_rdata;
        h_raddr           = rd_cnt_reg[HIW-1:0];
        b_we              = 1'b0;
        b_waddr           = di_reg[BIW-1:0];
        b_wdata           = b_rdata;
        b_raddr           = rd_cnt_reg[BIW-1:0];
        take              = 1'b0;
        keep              = 1'b0;

        // receiver takes the pending result
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // every scan state advances the read pointer the same way
        if ((state_reg == S_RQ_SCAN) || (state_reg == S_HOLE_PASS) ||
            (state_reg == S_BL_SCAN) || (state_reg == S_CP_PASS))
        begin
            if (issue)
            begin
                rd_cnt_next = rd_cnt_reg + CW'(1);
                dv_next     = 1'b1;
            end
        end

        unique case (state_reg)
            S_INIT:
            begin
                // one hole spanning all managed bytes
                h_we          = 1'b1;
                h_waddr       = '0;
                h_wdata       = {AW'(0), AW'(msize_reg - VW'(1))};
                hole_cnt_next = CW'(1);
                blk_cnt_next  = '0;
                state_next    = S_IDLE;
            end

            S_IDLE:
            begin
                rd_cnt_next = '0;
                wr_cnt_next = '0;
                found_next  = 1'b0;
                st_next     = cfa_pkg::ST_OK;
                rs_next     = '0;
                re_next     = '0;
                if (cfg_valid)
                begin
                    msize_next = VW'(cfg_sat);
                    state_next = S_INIT;
                end
                else if (in_valid)
                begin
                    owner_next = owner_id;
                    size_next  = request_size;
                    fit_next   = fit_strategy;
                    unique case (command)
                        cfa_pkg::CMD_REQUEST:
                        begin
                            if (blk_cnt_reg == CW'(TABLE_DEPTH))
                            begin
                                st_next    = cfa_pkg::ST_TABLE_FULL;
                                state_next = S_OUT;
                            end
                            else if ((request_size == '0) ||
                                     ((fit_strategy != cfa_pkg::FIT_FIRST) &&
                                      (fit_strategy != cfa_pkg::FIT_BEST) &&
                                      (fit_strategy != cfa_pkg::FIT_WORST)))
                            begin
                                st_next    = cfa_pkg::ST_NO_SPACE;
                                state_next = S_OUT;
                            end
                            else
                            begin
                                state_next = S_RQ_SCAN;
                            end
                        end
                        cfa_pkg::CMD_RELEASE: state_next = S_BL_SCAN;
                        cfa_pkg::CMD_COMPACT: state_next = S_CP_PASS;
                        default:              state_next = S_OUT;
                    endcase
                end
            end

            S_RQ_SCAN:
            begin
                if (dv_reg && (hs >= SW'(size_reg)))
                begin
                    unique case (fit_reg)
                        cfa_pkg::FIT_FIRST: take = !found_reg;
                        cfa_pkg::FIT_BEST:  take = !found_reg || (hs < pick_size_reg);
                        cfa_pkg::FIT_WORST: take = !found_reg || (hs > pick_size_reg);
                        default:            take = 1'b0;
                    endcase
                end
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_next      = di_reg;
                    pick_size_next = hs;
                    rs_next        = VW'(h_first);
                    pick_last_next = h_last;
                end
                if (scan_done)
                begin
                    if (!found_reg)
                    begin
                        st_next    = cfa_pkg::ST_NO_SPACE;
                        rs_next    = '0;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        re_next       = VW'(re_calc);
                        drop_next     = (AW'(re_calc) == pick_last_reg);
                        b_we          = 1'b1;
                        b_waddr       = blk_cnt_reg[BIW-1:0];
                        b_wdata       = {owner_reg, AW'(rs_reg), AW'(re_calc)};
                        blk_cnt_next  = blk_cnt_reg + CW'(1);
                        rel_mode_next = 1'b0;
                        rd_cnt_next   = '0;
                        wr_cnt_next   = '0;
                        state_next    = S_HOLE_PASS;
                    end
                end
            end

            S_BL_SCAN:
            begin
                if (dv_reg && !found_reg && (b_owner == owner_reg))
                begin
                    found_next = 1'b1;
                    pick_next  = di_reg;
                    rs_next    = VW'(b_first);
                    re_next    = VW'(b_last);
                end
                if (scan_done)
                begin
                    if (!found_reg)
                    begin
                        st_next    = cfa_pkg::ST_NOT_FOUND;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        // fetch the last block to fill the freed slot
                        b_raddr    = BIW'(blk_cnt_reg - CW'(1));
                        state_next = S_BL_MOVE;
                    end
                end
            end

            S_BL_MOVE:
            begin
                b_we          = 1'b1;
                b_waddr       = pick_reg[BIW-1:0];
                b_wdata       = b_rdata;
                blk_cnt_next  = blk_cnt_reg - CW'(1);
                rel_mode_next = 1'b1;
                rd_cnt_next   = '0;
                wr_cnt_next   = '0;
                state_next    = S_HOLE_PASS;
            end

            S_HOLE_PASS:
            begin
                // rewrite holes in order, dropping, trimming or merging as the command needs
                if (dv_reg)
                begin
                    keep    = 1'b1;
                    h_wdata = h_rdata;
                    if (!rel_mode_reg)
                    begin
                        if (di_reg == pick_reg)
                        begin
                            if (drop_reg)
                            begin
                                keep = 1'b0;
                            end
                            else
                            begin
                                h_wdata = {AW'(re_reg + VW'(1)), h_last};
                            end
                        end
                    end
                    else if ((VW'(h_last) + VW'(1)) == rs_reg)
                    begin
                        rs_next = VW'(h_first);
                        keep    = 1'b0;
                    end
                    else if (VW'(h_first) == (re_reg + VW'(1)))
                    begin
                        re_next = VW'(h_last);
                        keep    = 1'b0;
                    end
                    if (keep)
                    begin
                        h_we        = 1'b1;
                        wr_cnt_next = wr_cnt_reg + CW'(1);
                    end
                end
                if (scan_done)
                begin
                    hole_cnt_next = wr_cnt_reg;
                    if (rel_mode_reg && (wr_cnt_reg < CW'(HD)))
                    begin
                        h_we          = 1'b1;
                        h_wdata       = {AW'(rs_reg), AW'(re_reg)};
                        hole_cnt_next = wr_cnt_reg + CW'(1);
                    end
                    state_next = S_OUT;
                end
            end

            S_CP_PASS:
            begin
                // rs_reg runs as the packing address
                if (dv_reg)
                begin
                    b_we    = 1'b1;
                    b_waddr = di_reg[BIW-1:0];
                    b_wdata = {b_owner, AW'(rs_reg), AW'(cp_last)};
                    rs_next = rs_reg + bs;
                end
                if (scan_done)
                begin
                    re_next = msize_reg - VW'(1);
                    if (rs_reg < msize_reg)
                    begin
                        h_we          = 1'b1;
                        h_waddr       = '0;
                        h_wdata       = {AW'(rs_reg), AW'(msize_reg - VW'(1))};
                        hole_cnt_next = CW'(1);
                    end
                    else
                    begin
                        hole_cnt_next = '0;
                    end
                    state_next = S_OUT;
                end
            end

            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    status_next    = st_reg;
                    if (st_reg == cfa_pkg::ST_OK)
                    begin
                        region_start_next = FW'(rs_reg);
                        region_end_next   = FW'(re_reg);
                    end
                    else
                    begin
                        region_start_next = '0;
                        region_end_next   = '0;
                    end
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            msize_reg     <= MSIZE_RST;
            hole_cnt_reg  <= CW'(1);
            blk_cnt_reg   <= '0;
            rd_cnt_reg    <= '0;
            dv_reg        <= 1'b0;
            wr_cnt_reg    <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            msize_reg     <= msize_next;
            hole_cnt_reg  <= hole_cnt_next;
            blk_cnt_reg   <= blk_cnt_next;
            rd_cnt_reg    <= rd_cnt_next;
            dv_reg        <= dv_next;
            wr_cnt_reg    <= wr_cnt_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        owner_reg        <= owner_next;
        size_reg         <= size_next;
        fit_reg          <= fit_next;
        di_reg           <= di_next;
        pick_reg         <= pick_next;
        pick_size_reg    <= pick_size_next;
        pick_last_reg    <= pick_last_next;
        drop_reg         <= drop_next;
        rel_mode_reg     <= rel_mode_next;
        st_reg           <= st_next;
        rs_reg           <= rs_next;
        re_reg           <= re_next;
        status_reg       <= status_next;
        region_start_reg <= region_start_next;
        region_end_reg   <= region_end_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign region_start = region_start_reg;
    assign region_end   = region_end_reg;

endmodule
